>>> rtl/wom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wom_pkg
// Shared constants and types for the waveform min/max overview block.
// ----------------------------------------------------------------------------
package wom_pkg;

  localparam int OVERVIEW_BUCKETS = 1024;
  localparam int MAX_CHANNELS     = 2;

  localparam int BUCKET_BITS = (OVERVIEW_BUCKETS > 1) ? $clog2(OVERVIEW_BUCKETS) : 1;
  localparam int POS_W       = 32;
  localparam int NUM_W       = POS_W + BUCKET_BITS;
  localparam int CNT_W       = $clog2(BUCKET_BITS + 1);
  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 10;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 8'd1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_FOLD  = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_DROP  = 7'b1000000
  } wom_state_t;

endpackage

>>> rtl/waveform_overview_min_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_overview_min_max
// Min/max overview decimation: maps each frame to a bucket by iterative
// division and folds its samples into that bucket's stored extremes.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in_     | slave     | tdata: sample_first, sample_second
// out_    | master    | tdata: bucket_index, bucket_low, bucket_high; tuser: out_of_range
// cfg_    | slave     | cfg_index, cfg_data (always ready)
//
// a frame is accepted, then takes one restoring-divide step per quotient bit,
// a memory read, a fold/write and a load of the output register; a dropped
// frame skips divide, read and fold and passes a drop step to the output load
// after reset a clearing pass writes zero to all OVERVIEW_BUCKETS entries
// of the extremes memory, one per cycle, with in_tready low
// a stalled output holds the finished result; the next frame is still taken
// ----------------------------------------------------------------------------
module waveform_overview_min_max (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wom_pkg::IN_DATA_W-1:0]   in_tdata,   // sample_first, sample_second
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wom_pkg::OUT_DATA_W-1:0]  out_tdata,  // bucket_index, bucket_low, bucket_high, zero pad
  output logic                            out_tuser,  // out_of_range
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wom_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import wom_pkg::*;

  wom_state_t state_r, state_nxt;

  logic [POS_W-1:0]         total_r, total_nxt;
  logic [1:0]               chan_r, chan_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [POS_W-1:0]         rem_r, rem_nxt;
  logic [BUCKET_BITS-1:0]   num_lo_r, num_lo_nxt;
  logic [BUCKET_BITS-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [BUCKET_BITS-1:0]   clr_r, clr_nxt;
  logic signed [SAMPLE_W-1:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic signed [SAMPLE_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic                     oor_r, oor_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                     out_user_r, out_user_nxt;

  logic [2*SAMPLE_W-1:0]    mem [OVERVIEW_BUCKETS];
  logic [2*SAMPLE_W-1:0]    rd_data_r;
  logic                     wr_en;
  logic [BUCKET_BITS-1:0]   wr_addr;
  logic [2*SAMPLE_W-1:0]    wr_data;

  logic                     in_fire;
  logic [NUM_W-1:0]         num;
  logic [POS_W+1:0]         diff;
  logic                     ge;
  logic                     use_two;
  logic                     load_out;
  logic signed [SAMPLE_W-1:0] old_lo, old_hi, f_lo, f_hi;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // restoring divider step
  assign num  = NUM_W'(pos_r) * NUM_W'(OVERVIEW_BUCKETS);
  assign diff = {1'b0, rem_r, num_lo_r[BUCKET_BITS-1]} - {2'b00, total_r};
  assign ge   = ~diff[POS_W+1];

  assign use_two = (MAX_CHANNELS >= 2) && chan_r[1];
  assign old_lo  = rd_data_r[SAMPLE_W-1:0];
  assign old_hi  = rd_data_r[2*SAMPLE_W-1:SAMPLE_W];

  always_comb begin
    f_lo = old_lo;
    f_hi = old_hi;
    if (s0_r < f_lo) f_lo = s0_r;
    if (s0_r > f_hi) f_hi = s0_r;
    if (use_two && (s1_r < f_lo)) f_lo = s1_r;
    if (use_two && (s1_r > f_hi)) f_hi = s1_r;
  end

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    chan_nxt   = chan_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    num_lo_nxt = num_lo_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    s0_nxt     = s0_r;
    s1_nxt     = s1_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    oor_nxt    = oor_r;
    wr_en      = 1'b0;
    wr_addr    = q_r;
    wr_data    = {f_hi, f_lo};

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TOTAL_FRAMES) begin
        total_nxt = cfg_data;
      end else if (cfg_index == REG_CHANNELS_IN_USE) begin
        chan_nxt = cfg_data[1:0];
      end
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BUCKET_BITS'(OVERVIEW_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          s0_nxt     = in_tdata[SAMPLE_W-1:0];
          s1_nxt     = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
          rem_nxt    = num[NUM_W-1:BUCKET_BITS];
          num_lo_nxt = num[BUCKET_BITS-1:0];
          q_nxt      = '0;
          cnt_nxt    = '0;
          if ((total_r == '0) || (pos_r >= total_r)) begin
            state_nxt = ST_DROP;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (ge) begin
          rem_nxt = diff[POS_W-1:0];
        end else begin
          rem_nxt = {rem_r[POS_W-2:0], num_lo_r[BUCKET_BITS-1]};
        end
        q_nxt      = BUCKET_BITS'({q_r, ge});
        num_lo_nxt = num_lo_r << 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BUCKET_BITS - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        wr_en     = 1'b1;
        lo_nxt    = f_lo;
        hi_nxt    = f_hi;
        oor_nxt   = 1'b0;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DROP: begin
        q_nxt     = '0;
        lo_nxt    = '0;
        hi_nxt    = '0;
        oor_nxt   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(OUT_DATA_W - IDX_W - 2*SAMPLE_W)'(0), hi_r, lo_r, IDX_W'(q_r)};
      out_user_nxt  = oor_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[q_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      total_r     <= 32'd1;
      chan_r      <= 2'd2;
      pos_r       <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      chan_r      <= chan_nxt;
      pos_r       <= pos_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    num_lo_r   <= num_lo_nxt;
    q_r        <= q_nxt;
    s0_r       <= s0_nxt;
    s1_r       <= s1_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    oor_r      <= oor_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

>>> rtl/wom_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wom_checker
// Port-level checks for the waveform min/max overview block.
// ----------------------------------------------------------------------------
module wom_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [wom_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [wom_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wom_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import wom_pkg::*;

  // one frame in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a frame is in flight");

  // dropped frame carries all-zero fields
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("dropped frame has nonzero fields");

  // stored extremes start at zero: low never positive, high never negative
  a_extreme_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      ((out_tdata[25] || (out_tdata[25:10] == '0)) && !out_tdata[41]))
    else $error("bucket extremes on wrong side of zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output transaction changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind waveform_overview_min_max wom_checker u_wom_checker (.*);
